// File: hdl/tsrr_pkg.sv
// ---------------------------------------------------------------------------
// tsrr_pkg
// Shared types and constants for the thread-slot round-robin scheduler:
// command and status codes and the input and result transfer structs.
// ---------------------------------------------------------------------------
package tsrr_pkg;

  localparam int SLOT_COUNT_DEF  = 4;
  localparam int FRAME_BYTES_DEF = 7;
  localparam int SLOT_SHIFT      = 4;        // slot stride of 16 bytes
  localparam logic [7:0] STACK_BASE_RST = 8'h3F;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_SWITCH = 2'd1,
    CMD_EXIT   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] sp_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] slot_id;
    logic [7:0] load_sp;
    logic [7:0] frame_base;
    status_t    status;
  } out_item_t;

endpackage

// File: hdl/tsrr_pick.sv
// ---------------------------------------------------------------------------
// tsrr_pick
// Slot selection: lowest free slot, next live slot after the current one in
// rotating order, and lowest live slot once the current one is removed.
// ---------------------------------------------------------------------------
module tsrr_pick #(
  parameter int SLOT_COUNT = tsrr_pkg::SLOT_COUNT_DEF
) (
  input  logic [SLOT_COUNT-1:0]         live_mask,
  input  logic [$clog2(SLOT_COUNT)-1:0] cur_slot,
  output logic [$clog2(SLOT_COUNT)-1:0] free_idx,
  output logic                          free_any,
  output logic [$clog2(SLOT_COUNT)-1:0] rot_idx,
  output logic [$clog2(SLOT_COUNT)-1:0] low_idx,
  output logic                          low_any,
  output logic [SLOT_COUNT-1:0]         rest_mask
);

  localparam int SW = $clog2(SLOT_COUNT);

  assign rest_mask = live_mask & ~(SLOT_COUNT'(1) << cur_slot);

  // find-first from the top down so the lowest index wins
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    low_idx  = '0;
    low_any  = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!live_mask[i]) begin
        free_idx = SW'(i);
        free_any = 1'b1;
      end
      if (rest_mask[i]) begin
        low_idx = SW'(i);
        low_any = 1'b1;
      end
    end
  end

  // rotate: nearest live slot after cur, wrapping back to cur itself
  always_comb begin
    logic [SW:0] sum;
    rot_idx = cur_slot;
    for (int k = SLOT_COUNT; k >= 1; k--) begin
      sum = {1'b0, cur_slot} + (SW+1)'(k);
      if (sum >= (SW+1)'(SLOT_COUNT)) begin
        sum = sum - (SW+1)'(SLOT_COUNT);
      end
      if (live_mask[sum[SW-1:0]]) begin
        rot_idx = sum[SW-1:0];
      end
    end
  end

endmodule

// File: hdl/tsrr_core.sv
// ---------------------------------------------------------------------------
// tsrr_core
// Scheduler state (live mask, current slot, saved stack pointers) and the
// per-command result logic; state updates on each processed transfer.
// ---------------------------------------------------------------------------
module tsrr_core #(
  parameter int SLOT_COUNT  = tsrr_pkg::SLOT_COUNT_DEF,
  parameter int FRAME_BYTES = tsrr_pkg::FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  tsrr_pkg::in_item_t  item,
  input  logic [7:0]          stack_base,
  output logic                res_valid,
  output tsrr_pkg::out_item_t res
);

  localparam int SW = $clog2(SLOT_COUNT);

  logic [SLOT_COUNT-1:0] live_mask_r, live_mask_nxt;
  logic [SW-1:0]         cur_slot_r, cur_slot_nxt;
  logic                  cur_valid_r, cur_valid_nxt;
  logic [7:0]            saved_r [SLOT_COUNT];

  logic [SW-1:0]         free_idx, rot_idx, low_idx, rd_idx, wr_idx;
  logic                  free_any, low_any, wr_en;
  logic [SLOT_COUNT-1:0] rest_mask;
  logic [7:0]            frame, init_sp, wr_data, rd_data;

  tsrr_pick #(.SLOT_COUNT(SLOT_COUNT)) u_pick (
    .live_mask (live_mask_r),
    .cur_slot  (cur_slot_r),
    .free_idx  (free_idx),
    .free_any  (free_any),
    .rot_idx   (rot_idx),
    .low_idx   (low_idx),
    .low_any   (low_any),
    .rest_mask (rest_mask)
  );

  assign frame   = stack_base + 8'({free_idx, {tsrr_pkg::SLOT_SHIFT{1'b0}}});
  assign init_sp = frame + 8'(FRAME_BYTES);
  assign rd_data = saved_r[rd_idx];

  always_comb begin
    live_mask_nxt = live_mask_r;
    cur_slot_nxt  = cur_slot_r;
    cur_valid_nxt = cur_valid_r;
    wr_en         = 1'b0;
    wr_idx        = cur_slot_r;
    wr_data       = item.sp_in;
    rd_idx        = rot_idx;
    res_valid     = 1'b1;
    res           = '{slot_id: 2'd0, load_sp: 8'd0, frame_base: 8'd0,
                      status: tsrr_pkg::ST_OK};
    case (item.cmd)
      tsrr_pkg::CMD_CREATE: begin
        if (!free_any) begin
          res.status = tsrr_pkg::ST_FULL;
        end else begin
          live_mask_nxt = live_mask_r | (SLOT_COUNT'(1) << free_idx);
          wr_en         = 1'b1;
          wr_idx        = free_idx;
          wr_data       = init_sp;
          if (!cur_valid_r) begin
            cur_slot_nxt  = free_idx;
            cur_valid_nxt = 1'b1;
          end
          res.slot_id    = 2'(free_idx);
          res.load_sp    = init_sp;
          res.frame_base = frame;
        end
      end
      tsrr_pkg::CMD_SWITCH: begin
        if (!cur_valid_r) begin
          res.status = tsrr_pkg::ST_EMPTY;
        end else begin
          wr_en        = 1'b1;
          cur_slot_nxt = rot_idx;
          rd_idx       = rot_idx;
          res.slot_id  = 2'(rot_idx);
          // lone live thread gets back the pointer it just saved
          res.load_sp  = (rot_idx == cur_slot_r) ? item.sp_in : rd_data;
        end
      end
      tsrr_pkg::CMD_EXIT: begin
        if (!cur_valid_r) begin
          res.status = tsrr_pkg::ST_EMPTY;
        end else begin
          live_mask_nxt = rest_mask;
          if (!low_any) begin
            cur_valid_nxt = 1'b0;
            cur_slot_nxt  = '0;
            res.status    = tsrr_pkg::ST_EMPTY;
          end else begin
            cur_slot_nxt = low_idx;
            rd_idx       = low_idx;
            res.slot_id  = 2'(low_idx);
            res.load_sp  = rd_data;
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_mask_r <= '0;
      cur_slot_r  <= '0;
      cur_valid_r <= 1'b0;
    end else if (fire) begin
      live_mask_r <= live_mask_nxt;
      cur_slot_r  <= cur_slot_nxt;
      cur_valid_r <= cur_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      saved_r[wr_idx] <= wr_data;
    end
  end

`ifndef SYNTH
  a_cur_live: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> live_mask_r[cur_slot_r])
    else $error("current slot is not live");

  a_idle_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !cur_valid_r |-> (cur_slot_r == '0) && (live_mask_r == '0))
    else $error("no current thread but slots still held");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == tsrr_pkg::ST_FULL) |->
      (item.cmd == tsrr_pkg::CMD_CREATE) && (&live_mask_r))
    else $error("full status without a full live mask");
`endif

endmodule

// File: hdl/thread_slot_round_robin_scheduler.sv
// ---------------------------------------------------------------------------
// thread_slot_round_robin_scheduler
// Thread-slot manager: create, switch and exit commands over a set of slots
// with live mask, current slot and saved stack pointers.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | in_item  (cmd, sp_in)
//  out_    | output    | out_valid/out_stall | out_item (slot_id, load_sp,
//          |           |                     |           frame_base, status)
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_data (stack_base)
//
// an accepted command is held in the input register, then the slot logic
// evaluates it and loads the result register; one command per cycle is
// sustained while the result side is not stalled.
// command code 3 is dropped and produces no result transfer.
// reset clears the live mask and current slot and sets stack_base to 0x3F.
// a stalled result holds the result register; the input register keeps
// accepting until it is full behind it.
// ---------------------------------------------------------------------------
module thread_slot_round_robin_scheduler #(
  parameter int SLOT_COUNT  = tsrr_pkg::SLOT_COUNT_DEF,
  parameter int FRAME_BYTES = tsrr_pkg::FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsrr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tsrr_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  tsrr_pkg::in_item_t  in_item_r;
  logic                in_full_r, in_full_nxt;
  tsrr_pkg::out_item_t out_item_r;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          stack_base_r;

  logic                advance, accept, res_valid;
  tsrr_pkg::out_item_t res;

  assign advance   = in_full_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_full_r && !advance;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  tsrr_core #(
    .SLOT_COUNT  (SLOT_COUNT),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (advance),
    .item       (in_item_r),
    .stack_base (stack_base_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_comb begin
    in_full_nxt = in_full_r;
    if (accept) begin
      in_full_nxt = 1'b1;
    end else if (advance) begin
      in_full_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      stack_base_r <= tsrr_pkg::STACK_BASE_RST;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        stack_base_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r <= in_item;
    end
    if (advance && res_valid) begin
      out_item_r <= res;
    end
  end

`ifndef SYNTH
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid) |=> out_valid_r)
    else $error("processed command left no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_full_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_item_r)))
    else $error("stalled result changed");
`endif

endmodule

// File: sim/thread_slot_round_robin_scheduler_checker.sv
// ---------------------------------------------------------------------------
// thread_slot_round_robin_scheduler_checker
// Watches the command, result and stack_base channels of the scheduler,
// tracks its own copy of the live mask, current slot and saved stack
// pointers, and compares every result transfer against the oldest
// prediction. Reports a failure count and the number of results in flight.
// ---------------------------------------------------------------------------
module thread_slot_round_robin_scheduler_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  tsrr_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  tsrr_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  output int                  fail_count,
  output int                  pending
);

  logic [3:0] live_slots;
  logic [1:0] cur_slot;
  logic       cur_valid;
  logic [7:0] saved_sp [4];
  logic [7:0] stack_base;

  tsrr_pkg::out_item_t sched_results_q[$];
  int mismatches = 0;

  task automatic predict_schedule(input tsrr_pkg::in_item_t cmd_in);
    tsrr_pkg::out_item_t r;
    logic [1:0] s;
    logic [7:0] fb;
    bit         found;
    r     = '0;
    s     = '0;
    found = 1'b0;
    case (cmd_in.cmd)
      tsrr_pkg::CMD_CREATE: begin
        if (&live_slots) begin
          r.status = tsrr_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < 4; i++) begin
            if (!found && !live_slots[i]) begin
              s     = 2'(i);
              found = 1'b1;
            end
          end
          live_slots[s] = 1'b1;
          fb            = stack_base + 8'({s, 4'b0000});
          saved_sp[s]   = fb + 8'(tsrr_pkg::FRAME_BYTES_DEF);
          if (!cur_valid) begin
            cur_slot  = s;
            cur_valid = 1'b1;
          end
          r.slot_id    = s;
          r.load_sp    = saved_sp[s];
          r.frame_base = fb;
        end
        sched_results_q.push_back(r);
      end
      tsrr_pkg::CMD_SWITCH: begin
        if (!cur_valid) begin
          r.status = tsrr_pkg::ST_EMPTY;
        end else begin
          saved_sp[cur_slot] = cmd_in.sp_in;
          // rotate from the slot after the current one, ending on itself
          for (int k = 1; k <= 4; k++) begin
            if (!found && live_slots[cur_slot + 2'(k)]) begin
              s     = cur_slot + 2'(k);
              found = 1'b1;
            end
          end
          cur_slot  = s;
          r.slot_id = s;
          r.load_sp = saved_sp[s];
        end
        sched_results_q.push_back(r);
      end
      tsrr_pkg::CMD_EXIT: begin
        if (!cur_valid) begin
          r.status = tsrr_pkg::ST_EMPTY;
        end else begin
          live_slots[cur_slot] = 1'b0;
          if (live_slots == 4'b0000) begin
            cur_valid = 1'b0;
            cur_slot  = '0;
            r.status  = tsrr_pkg::ST_EMPTY;
          end else begin
            for (int i = 0; i < 4; i++) begin
              if (!found && live_slots[i]) begin
                s     = 2'(i);
                found = 1'b1;
              end
            end
            cur_slot  = s;
            r.slot_id = s;
            r.load_sp = saved_sp[s];
          end
        end
        sched_results_q.push_back(r);
      end
      default: begin
        // reserved code: dropped by the block
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    tsrr_pkg::out_item_t want;
    if (!rst_n) begin
      live_slots = '0;
      cur_slot   = '0;
      cur_valid  = 1'b0;
      stack_base = tsrr_pkg::STACK_BASE_RST;
      for (int i = 0; i < 4; i++) saved_sp[i] = '0;
      sched_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) stack_base = cfg_data;
      if (out_valid && !out_stall) begin
        if (sched_results_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result transfer: slot %0d sp %02h fb %02h status %0d",
                     out_item.slot_id, out_item.load_sp, out_item.frame_base,
                     out_item.status);
          mismatches++;
        end else begin
          want = sched_results_q.pop_front();
          if (out_item.slot_id !== want.slot_id || out_item.load_sp !== want.load_sp ||
              out_item.frame_base !== want.frame_base || out_item.status !== want.status)
          begin
            if (mismatches < 10)
              $display("result mismatch: want slot %0d sp %02h fb %02h status %0d,",
                       want.slot_id, want.load_sp, want.frame_base, want.status,
                       " got slot %0d sp %02h fb %02h status %0d",
                       out_item.slot_id, out_item.load_sp, out_item.frame_base,
                       out_item.status);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) predict_schedule(in_item);
    end
    pending    <= sched_results_q.size();
    fail_count <= mismatches;
  end

endmodule

// File: sim/thread_slot_round_robin_scheduler_tb.sv
// ---------------------------------------------------------------------------
// thread_slot_round_robin_scheduler_tb
// Drives create, switch, exit and reserved commands into the scheduler with
// random gaps and result stalls, reprograms stack_base between phases while
// idle, and gives the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module thread_slot_round_robin_scheduler_tb;

  localparam logic [1:0] CMD_RSVD   = 2'd3;
  localparam int         CYCLE_MAX  = 200000;
  localparam int         PHASE_CMDS = 290;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  tsrr_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tsrr_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_data  = '0;

  int fail_count;
  int pending;
  int cycle_cnt  = 0;
  int stall_left = 0;
  bit calm       = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  thread_slot_round_robin_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  thread_slot_round_robin_scheduler_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: stall for a drawn number of cycles after each transfer
  always @(posedge clk) begin : result_stall
    int n;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left != 1);
    end else if (out_valid && !out_stall) begin
      n = pick_gap();
      stall_left <= n;
      out_stall  <= (n != 0);
    end
  end

  task automatic send_cmd(input logic [1:0] c, input logic [7:0] sp);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{cmd: tsrr_pkg::cmd_t'(c), sp_in: sp};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off until every predicted result has arrived, then wait with the
  // input idle so the pipeline drains
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] bases [5];
    int counted;
    int roll;
    int create_pct;
    int exit_pct;
    logic [1:0] c;
    bases[0] = 8'h00;
    bases[1] = 8'hFF;
    bases[2] = 8'hF8;
    bases[3] = 8'($urandom_range(0, 255));
    bases[4] = 8'h3F;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // nothing live yet, then fill every slot and overflow
    send_cmd(tsrr_pkg::CMD_SWITCH, 8'h5A);
    send_cmd(tsrr_pkg::CMD_EXIT, 8'hA5);
    send_cmd(CMD_RSVD, 8'hFF);
    repeat (4) send_cmd(tsrr_pkg::CMD_CREATE, 8'h00);
    send_cmd(tsrr_pkg::CMD_CREATE, 8'hFF);
    send_cmd(tsrr_pkg::CMD_SWITCH, 8'hFF);
    send_cmd(tsrr_pkg::CMD_SWITCH, 8'h00);
    send_cmd(tsrr_pkg::CMD_EXIT, 8'h33);
    send_cmd(tsrr_pkg::CMD_EXIT, 8'hCC);
    send_cmd(tsrr_pkg::CMD_EXIT, 8'h11);
    // lone thread switches back to itself
    send_cmd(tsrr_pkg::CMD_SWITCH, 8'hA5);
    send_cmd(tsrr_pkg::CMD_SWITCH, 8'h5A);
    send_cmd(tsrr_pkg::CMD_EXIT, 8'h00);
    send_cmd(tsrr_pkg::CMD_SWITCH, 8'h77);
    settle();

    // region addresses wrap past 0xFF
    write_base(8'hFF);
    repeat (4) send_cmd(tsrr_pkg::CMD_CREATE, 8'h00);
    send_cmd(tsrr_pkg::CMD_SWITCH, 8'h80);
    send_cmd(tsrr_pkg::CMD_EXIT, 8'h01);
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      write_base(bases[phase]);
      counted    = 0;
      create_pct = 30;
      exit_pct   = 20;
      while (counted < PHASE_CMDS) begin
        if (counted % 40 == 0) begin
          calm       = ($urandom_range(0, 3) == 0);
          create_pct = $urandom_range(15, 40);
          exit_pct   = $urandom_range(15, 35);
        end
        if (counted == PHASE_CMDS / 2) settle();
        roll = $urandom_range(0, 99);
        if (roll < create_pct)
          c = tsrr_pkg::CMD_CREATE;
        else if (roll < create_pct + exit_pct)
          c = tsrr_pkg::CMD_EXIT;
        else if (roll < 96)
          c = tsrr_pkg::CMD_SWITCH;
        else
          c = CMD_RSVD;
        send_cmd(c, 8'($urandom_range(0, 255)));
        if (c != CMD_RSVD) counted++;
      end
      settle();
    end

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
